// ===== rtl/lfu_pkg.sv =====
// ----------------------------------------------------------------------------
// lfu_pkg
// Shared types and constants for the LFU cache table.
// ----------------------------------------------------------------------------
package lfu_pkg;

	localparam int unsigned ENTRIES_DEF = 16;
	localparam int unsigned CAP_W = 5;
	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;
	localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

	localparam logic OP_GET = 1'b0;
	localparam logic OP_PUT = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DECIDE,
		ST_EVICT,
		ST_UPDATE,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic scan_clear;
		logic scan_step;
		logic do_evict;
		logic do_hit;
		logic do_insert;
		logic respond;
	} ctrl_t;

	typedef struct packed {
		logic scan_last;
		logic found;
		logic full;
		logic disabled;
		logic is_put;
		logic has_free;
		logic has_victim;
	} stat_t;

endpackage

// ===== rtl/lfu_ctrl.sv =====
// ----------------------------------------------------------------------------
// lfu_ctrl
// Request sequencer: scan, decide, evict/insert or hit update, respond.
// ----------------------------------------------------------------------------
module lfu_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  lfu_pkg::stat_t  stat,
	output lfu_pkg::ctrl_t  ctrl,
	output logic            busy
);

	lfu_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= lfu_pkg::ST_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		ctrl = '0;
		busy = (state_q != lfu_pkg::ST_IDLE);
		case (state_q)
			lfu_pkg::ST_IDLE: begin
				if (start) begin
					ctrl.scan_clear = 1'b1;
					state_d = lfu_pkg::ST_SCAN;
				end
			end
			lfu_pkg::ST_SCAN: begin
				ctrl.scan_step = 1'b1;
				if (stat.scan_last) state_d = lfu_pkg::ST_DECIDE;
			end
			lfu_pkg::ST_DECIDE: begin
				if (stat.disabled) state_d = lfu_pkg::ST_DONE;
				else if (stat.found) state_d = lfu_pkg::ST_UPDATE;
				else if (!stat.is_put) state_d = lfu_pkg::ST_DONE;
				else if (stat.full && stat.has_victim) state_d = lfu_pkg::ST_EVICT;
				else state_d = lfu_pkg::ST_UPDATE;
			end
			lfu_pkg::ST_EVICT: begin
				ctrl.do_evict = 1'b1;
				state_d = lfu_pkg::ST_UPDATE;
			end
			lfu_pkg::ST_UPDATE: begin
				if (stat.found) ctrl.do_hit = 1'b1;
				else if (stat.has_free) ctrl.do_insert = 1'b1;
				state_d = lfu_pkg::ST_DONE;
			end
			lfu_pkg::ST_DONE: begin
				ctrl.respond = 1'b1;
				state_d = lfu_pkg::ST_IDLE;
			end
			default: state_d = lfu_pkg::ST_IDLE;
		endcase
	end

endmodule

// ===== rtl/lfu_dp.sv =====
// ----------------------------------------------------------------------------
// lfu_dp
// Entry table with one-slot-per-cycle scan for key match, victim and free slot.
// ----------------------------------------------------------------------------
module lfu_dp #(
	parameter int unsigned ENTRIES = lfu_pkg::ENTRIES_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic                     busy,
	input  logic                     opcode,
	input  logic [31:0]              lookup_key,
	input  logic signed [31:0]       write_value,
	input  logic [lfu_pkg::CAP_W-1:0] cap_cfg,
	input  lfu_pkg::ctrl_t           ctrl,
	output lfu_pkg::stat_t           stat,
	output logic                     hit,
	output logic signed [31:0]       read_value,
	output logic                     done
);

	localparam int unsigned IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int unsigned OW = $clog2(ENTRIES + 1);

	logic [ENTRIES-1:0] valid_q;
	logic [31:0]        key_q   [ENTRIES];
	logic [31:0]        data_q  [ENTRIES];
	logic [31:0]        cnt_q   [ENTRIES];
	logic [IW-1:0]      rank_q  [ENTRIES];
	logic [OW-1:0]      occ_q;

	logic               op_q;
	logic [31:0]        rkey_q;
	logic [31:0]        rval_q;
	logic [IW-1:0]      idx_q;
	logic               found_q, vic_ok_q, free_ok_q;
	logic [IW-1:0]      hit_idx_q, vic_idx_q, free_idx_q;
	logic [31:0]        vic_cnt_q;
	logic [IW-1:0]      vic_rank_q;
	logic               hit_q;
	logic [31:0]        rd_q;
	logic               done_q;
	logic [OW-1:0]      cap_eff;

	always_comb begin
		if ({{(32-lfu_pkg::CAP_W){1'b0}}, cap_cfg} > ENTRIES) cap_eff = OW'(ENTRIES);
		else cap_eff = OW'(cap_cfg);
	end

	logic cur_v, cur_match, cur_better;
	always_comb begin
		cur_v = valid_q[idx_q];
		cur_match = cur_v && (key_q[idx_q] == rkey_q);
		cur_better = cur_v && (!vic_ok_q || (cnt_q[idx_q] < vic_cnt_q) ||
			((cnt_q[idx_q] == vic_cnt_q) && (rank_q[idx_q] > vic_rank_q)));
	end

	assign stat.scan_last  = ({{(32-IW){1'b0}}, idx_q} == ENTRIES - 1);
	assign stat.found      = found_q;
	assign stat.full       = ({{(32-OW){1'b0}}, occ_q} >= {{(32-OW){1'b0}}, cap_eff});
	assign stat.disabled   = (cap_eff == '0);
	assign stat.is_put     = (op_q == lfu_pkg::OP_PUT);
	assign stat.has_free   = free_ok_q;
	assign stat.has_victim = vic_ok_q;

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			op_q   <= opcode;
			rkey_q <= lookup_key;
			rval_q <= write_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= '0;
			occ_q     <= '0;
			idx_q     <= '0;
			found_q   <= 1'b0;
			vic_ok_q  <= 1'b0;
			free_ok_q <= 1'b0;
			done_q    <= 1'b0;
			hit_q     <= 1'b0;
			rd_q      <= '0;
		end else begin
			done_q <= ctrl.respond;
			if (ctrl.scan_clear) begin
				idx_q     <= '0;
				found_q   <= 1'b0;
				vic_ok_q  <= 1'b0;
				free_ok_q <= 1'b0;
			end
			if (ctrl.scan_step) begin
				idx_q <= idx_q + 1'b1;
				if (cur_match && !found_q) begin
					found_q   <= 1'b1;
					hit_idx_q <= idx_q;
				end
				if (cur_better) begin
					vic_ok_q   <= 1'b1;
					vic_idx_q  <= idx_q;
					vic_cnt_q  <= cnt_q[idx_q];
					vic_rank_q <= rank_q[idx_q];
				end
				if (!cur_v && !free_ok_q) begin
					free_ok_q  <= 1'b1;
					free_idx_q <= idx_q;
				end
			end
			if (ctrl.do_evict) begin
				valid_q[vic_idx_q] <= 1'b0;
				for (int i = 0; i < ENTRIES; i++)
					if (valid_q[i] && rank_q[i] > vic_rank_q) rank_q[i] <= rank_q[i] - 1'b1;
				occ_q <= occ_q - 1'b1;
				free_ok_q  <= 1'b1;
				free_idx_q <= (free_ok_q && free_idx_q < vic_idx_q) ? free_idx_q : vic_idx_q;
			end
			if (ctrl.do_hit) begin
				for (int i = 0; i < ENTRIES; i++)
					if (valid_q[i] && rank_q[i] < rank_q[hit_idx_q]) rank_q[i] <= rank_q[i] + 1'b1;
				rank_q[hit_idx_q] <= '0;
				if (cnt_q[hit_idx_q] != lfu_pkg::COUNT_MAX)
					cnt_q[hit_idx_q] <= cnt_q[hit_idx_q] + 32'd1;
				if (op_q == lfu_pkg::OP_PUT) data_q[hit_idx_q] <= rval_q;
			end
			if (ctrl.do_insert) begin
				for (int i = 0; i < ENTRIES; i++)
					if (valid_q[i]) rank_q[i] <= rank_q[i] + 1'b1;
				valid_q[free_idx_q] <= 1'b1;
				key_q[free_idx_q]   <= rkey_q;
				data_q[free_idx_q]  <= rval_q;
				cnt_q[free_idx_q]   <= 32'd1;
				rank_q[free_idx_q]  <= '0;
				occ_q <= occ_q + 1'b1;
			end
			if (ctrl.respond) begin
				hit_q <= found_q && !stat.disabled;
				rd_q  <= (found_q && !stat.disabled && op_q == lfu_pkg::OP_GET) ?
					data_q[hit_idx_q] : 32'd0;
			end
		end
	end

	assign hit        = hit_q;
	assign read_value = rd_q;
	assign done       = done_q;

endmodule

// ===== rtl/lfu_cache_table.sv =====
// Path from the accepting edge to done: slot-by-slot scan, decide, evict (evicting put only),
// update (hit or plain insert), done state, then the registered done; get miss or disabled skip both.
// A new request is taken only once the sequencer is back in idle, after the previous done state.
// The result strobe done lasts one cycle; the receiver cannot stall.
// Reset: asynchronous, clears valid bits, occupancy and control; capacity 16.
// ----------------------------------------------------------------------------
// lfu_cache_table
// LFU key-value cache, LRU tie-break, sequencer plus datapath.
// ----------------------------------------------------------------------------
module lfu_cache_table #(
	parameter int unsigned ENTRIES = lfu_pkg::ENTRIES_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic                      opcode,
	input  logic [31:0]               lookup_key,
	input  logic signed [31:0]        write_value,
	output logic                      done,
	output logic                      hit,
	output logic signed [31:0]        read_value,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [lfu_pkg::CAP_W-1:0] cfg_data
);

	lfu_pkg::ctrl_t ctrl;
	lfu_pkg::stat_t stat;
	logic [lfu_pkg::CAP_W-1:0] cap_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) cap_q <= lfu_pkg::CAP_RESET;
		else if (cfg_valid && cfg_ready) cap_q <= cfg_data;
	end

	lfu_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .stat(stat), .ctrl(ctrl), .busy(busy)
	);

	lfu_dp #(.ENTRIES(ENTRIES)) u_dp (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .opcode(opcode),
		.lookup_key(lookup_key), .write_value(write_value), .cap_cfg(cap_q),
		.ctrl(ctrl), .stat(stat), .hit(hit), .read_value(read_value), .done(done)
	);

endmodule

// ===== rtl/lfu_checker.sv =====
// ----------------------------------------------------------------------------
// lfu_checker
// Port-level checks for the LFU cache table.
// ----------------------------------------------------------------------------
module lfu_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               start,
	input logic               busy,
	input logic               done,
	input logic               hit,
	input logic signed [31:0] read_value
);

	a_busy_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("busy not raised");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("done longer than one cycle");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("done while busy");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !hit |-> read_value == 32'sd0) else $error("miss with data");

endmodule

bind lfu_cache_table lfu_checker u_chk (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
	.done(done), .hit(hit), .read_value(read_value)
);

// ===== tb/sv/lfu_cache_table_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfu_cache_table_tb
// Drives get/put requests and capacity writes into the LFU cache table and
// checks each response against a behavioral copy of the table kept here.
// ----------------------------------------------------------------------------

class cache_scoreboard;
	typedef struct {
		logic        hit;
		logic [31:0] value;
	} resp_t;

	bit          slot_valid [16];
	logic [31:0] slot_key   [16];
	logic [31:0] slot_data  [16];
	logic [31:0] slot_uses  [16];
	int          slot_rank  [16];
	int          occupancy;
	int          capacity;
	resp_t       expected_resp[$];
	int          errors;

	function new();
		for (int i = 0; i < 16; i++) slot_valid[i] = 0;
		occupancy = 0;
		capacity  = lfu_pkg::CAP_RESET;
		errors    = 0;
	endfunction

	function void set_capacity(logic [lfu_pkg::CAP_W-1:0] v);
		capacity = v;
	endfunction

	function int pending();
		return expected_resp.size();
	endfunction

	function void touch(int s);
		int r;
		r = slot_rank[s];
		for (int i = 0; i < 16; i++)
			if (slot_valid[i] && slot_rank[i] < r) slot_rank[i]++;
		slot_rank[s] = 0;
		if (slot_uses[s] != lfu_pkg::COUNT_MAX) slot_uses[s]++;
	endfunction

	function void evict_one();
		int v;
		int r;
		v = -1;
		for (int i = 0; i < 16; i++) begin
			if (!slot_valid[i]) continue;
			if (v < 0 || slot_uses[i] < slot_uses[v] ||
			    (slot_uses[i] == slot_uses[v] && slot_rank[i] > slot_rank[v]))
				v = i;
		end
		if (v < 0) return;
		r = slot_rank[v];
		slot_valid[v] = 0;
		for (int i = 0; i < 16; i++)
			if (slot_valid[i] && slot_rank[i] > r) slot_rank[i]--;
		if (occupancy > 0) occupancy--;
	endfunction

	function void insert_new(logic [31:0] k, logic [31:0] v);
		int f;
		f = -1;
		for (int i = 0; i < 16; i++)
			if (!slot_valid[i]) begin
				f = i;
				break;
			end
		if (f < 0) return;
		for (int i = 0; i < 16; i++)
			if (slot_valid[i]) slot_rank[i]++;
		slot_valid[f] = 1;
		slot_key[f]   = k;
		slot_data[f]  = v;
		slot_uses[f]  = 32'd1;
		slot_rank[f]  = 0;
		occupancy++;
	endfunction

	function void note_request(logic op, logic [31:0] k, logic [31:0] v);
		resp_t r;
		int    s;
		int    cap;
		r.hit   = 1'b0;
		r.value = 32'd0;
		s       = -1;
		cap     = capacity > 16 ? 16 : capacity;
		if (cap != 0) begin
			for (int i = 0; i < 16; i++)
				if (s < 0 && slot_valid[i] && slot_key[i] == k) s = i;
			if (s >= 0) begin
				r.hit = 1'b1;
				touch(s);
				if (op == lfu_pkg::OP_PUT) slot_data[s] = v;
				else r.value = slot_data[s];
			end else if (op == lfu_pkg::OP_PUT) begin
				if (occupancy >= cap) evict_one();
				insert_new(k, v);
			end
		end
		expected_resp.push_back(r);
	endfunction

	function void check_response(logic h, logic [31:0] v);
		resp_t e;
		if (expected_resp.size() == 0) begin
			errors++;
			if (errors <= 10) $display("unexpected response hit=%0b value=%h", h, v);
			return;
		end
		e = expected_resp.pop_front();
		if (h !== e.hit || v !== e.value) begin
			errors++;
			if (errors <= 10)
				$display("mismatch: expected hit=%0b value=%h, got hit=%0b value=%h",
					e.hit, e.value, h, v);
		end
	endfunction
endclass

module lfu_cache_table_tb;
	logic                        clk = 0;
	logic                        arst_n = 0;
	logic                        start = 0;
	logic                        busy;
	logic                        opcode = lfu_pkg::OP_GET;
	logic [31:0]                 lookup_key = 0;
	logic signed [31:0]          write_value = 0;
	logic                        done;
	logic                        hit;
	logic signed [31:0]          read_value;
	logic                        cfg_valid = 0;
	logic                        cfg_ready;
	logic [lfu_pkg::CAP_W-1:0]   cfg_data = 0;

	cache_scoreboard sb = new();
	logic [31:0]     key_pool[24];
	bit              no_gaps;
	int              cycles = 0;

	lfu_cache_table dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.opcode(opcode), .lookup_key(lookup_key), .write_value(write_value),
		.done(done), .hit(hit), .read_value(read_value),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	always begin
		#1 clk = 1;
		#1 clk = 0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 400000) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready) sb.set_capacity(cfg_data);
			if (start && !busy) sb.note_request(opcode, lookup_key, write_value);
			if (done) sb.check_response(hit, read_value);
		end
	end

	task automatic send_request(logic op, logic [31:0] k, logic [31:0] v);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, 11);
		if (gap > 0) begin
			start <= 0;
			repeat (gap) @(posedge clk);
		end
		start       <= 1;
		opcode      <= op;
		lookup_key  <= k;
		write_value <= v;
		do @(posedge clk); while (busy);
	endtask

	task automatic drain();
		start <= 0;
		do @(posedge clk); while (sb.pending() != 0 || busy);
	endtask

	task automatic write_capacity(logic [lfu_pkg::CAP_W-1:0] v);
		drain();
		repeat (25) @(posedge clk);
		cfg_valid <= 1;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 0;
		@(posedge clk);
	endtask

	task automatic random_request();
		logic [31:0] k;
		logic        op;
		k  = ($urandom_range(0, 19) == 0) ? $urandom() : key_pool[$urandom_range(0, 23)];
		op = 1'($urandom_range(0, 1));
		send_request(op, k, $urandom());
	endtask

	int caps[7] = '{31, 0, 1, 4, 16, 9, 2};

	initial begin
		for (int i = 0; i < 24; i++) key_pool[i] = $urandom();
		no_gaps = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: extremes, update, fill past capacity
		send_request(lfu_pkg::OP_GET, 32'h0, 32'h0);
		send_request(lfu_pkg::OP_PUT, 32'h0, 32'h8000_0000);
		send_request(lfu_pkg::OP_PUT, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
		send_request(lfu_pkg::OP_GET, 32'h0, 32'h0);
		send_request(lfu_pkg::OP_GET, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_request(lfu_pkg::OP_PUT, 32'h0, 32'h1234_5678);
		send_request(lfu_pkg::OP_GET, 32'h0, 32'h0);
		for (int i = 0; i < 16; i++) send_request(lfu_pkg::OP_PUT, key_pool[i], 32'(i));
		send_request(lfu_pkg::OP_GET, 32'hFFFF_FFFF, 32'h0);
		drain();
		// capacity lowered below occupancy
		write_capacity(5'd3);
		send_request(lfu_pkg::OP_GET, key_pool[15], 32'h0);
		send_request(lfu_pkg::OP_PUT, key_pool[20], 32'hA5A5_A5A5);
		send_request(lfu_pkg::OP_GET, key_pool[20], 32'h0);

		foreach (caps[p]) begin
			write_capacity(lfu_pkg::CAP_W'(caps[p]));
			for (int n = 0; n < 140; n++) begin
				if (n % 50 == 0) no_gaps = $urandom_range(0, 2) == 0;
				if (n == 70) drain();
				random_request();
			end
		end

		drain();
		repeat (30) @(posedge clk);
		if (sb.errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end
endmodule
